// ===== src/spq_pkg.sv =====
// Package for the sorted priority queue: request codes, fixed field widths
// and the control word that the top level sends to every storage cell.
// No dependencies.
package spq_pkg;

	localparam logic [2:0] REQ_INSERT  = 3'd0;
	localparam logic [2:0] REQ_POLL    = 3'd1;
	localparam logic [2:0] REQ_PEEK    = 3'd2;
	localparam logic [2:0] REQ_READ_AT = 3'd3;
	localparam logic [2:0] REQ_REM_TAG = 3'd4;
	localparam logic [2:0] REQ_REM_AT  = 3'd5;
	localparam logic [2:0] REQ_COUNT   = 3'd6;

	localparam int POS_W = 4;
	localparam int CNT_W = 5;

	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctrl_t;

endpackage

// ===== src/spq_if.sv =====
// Request and response channel interfaces of the sorted priority queue.
// Depends on spq_pkg for the fixed field widths.
interface spq_req_if #(
	parameter int KEY_BITS = 16,
	parameter int TAG_BITS = 8
);
	logic                       valid;
	logic                       ready;
	logic [2:0]                 req_type;
	logic [KEY_BITS-1:0]        prio_key;
	logic [TAG_BITS-1:0]        entry_tag;
	logic [spq_pkg::POS_W-1:0]  position;

	modport source (output valid, req_type, prio_key, entry_tag, position, input ready);
	modport sink (input valid, req_type, prio_key, entry_tag, position, output ready);
endinterface

interface spq_rsp_if #(
	parameter int KEY_BITS = 16,
	parameter int TAG_BITS = 8
);
	logic                       valid;
	logic                       ready;
	logic                       ok;
	logic [TAG_BITS-1:0]        out_tag;
	logic [KEY_BITS-1:0]        out_key;
	logic [spq_pkg::CNT_W-1:0]  out_position;
	logic [spq_pkg::CNT_W-1:0]  occupancy;

	modport source (output valid, ok, out_tag, out_key, out_position, occupancy, input ready);
	modport sink (input valid, ok, out_tag, out_key, out_position, occupancy, output ready);
endinterface

// ===== src/spq_cell.sv =====
// One storage cell of the sorted chain: holds a key and a tag and loads
// a new entry or its neighbor's entry. Depends on spq_pkg.
module spq_cell #(
	parameter int KEY_BITS = 16,
	parameter int TAG_BITS = 8,
	parameter int CNT_BITS = 5,
	parameter int IDX      = 0
) (
	input  logic                    clk,
	input  spq_pkg::cell_ctrl_t     ctrl,
	input  logic [CNT_BITS-1:0]     count,
	input  logic [CNT_BITS-1:0]     rem_pos,
	input  logic [KEY_BITS-1:0]     new_key,
	input  logic [TAG_BITS-1:0]     new_tag,
	input  logic                    prev_le,
	input  logic [KEY_BITS-1:0]     prev_key,
	input  logic [TAG_BITS-1:0]     prev_tag,
	input  logic [KEY_BITS-1:0]     next_key,
	input  logic [TAG_BITS-1:0]     next_tag,
	output logic                    le,
	output logic [KEY_BITS-1:0]     key_q,
	output logic [TAG_BITS-1:0]     tag_q
);
	localparam logic [CNT_BITS:0] IDX_W = (CNT_BITS+1)'(IDX);

	logic in_use;
	logic in_reach;
	logic take_new;
	logic take_prev;
	logic take_next;

	assign in_use    = IDX_W < {1'b0, count};
	assign in_reach  = IDX_W <= {1'b0, count};
	assign le        = in_use && (key_q <= new_key);
	assign take_new  = ctrl.ins && !le && prev_le && in_reach;
	assign take_prev = ctrl.ins && !le && !prev_le && in_reach;
	assign take_next = ctrl.rem && (IDX_W >= {1'b0, rem_pos}) && (IDX_W + 1'b1 < {1'b0, count});

	always_ff @(posedge clk) begin
		if (take_new) begin
			key_q <= new_key;
			tag_q <= new_tag;
		end else if (take_prev) begin
			key_q <= prev_key;
			tag_q <= prev_tag;
		end else if (take_next) begin
			key_q <= next_key;
			tag_q <= next_tag;
		end
	end

endmodule

// ===== src/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: request decode, the chain of cells
// and the response register. Depends on spq_pkg, spq_if and spq_cell.
//
//   channel | modport     | payload
//   req     | sink        | req_type, prio_key, entry_tag, position
//   rsp     | source      | ok, out_tag, out_key, out_position, occupancy
//
// A request is first registered; then every cell compares and shifts at once,
// once the response can be written. Removing by tag walks the chain one position
// per cycle, staying on a position while it removes a matching entry there.
// Reset clears the state, the count and the response valid; cell contents are not reset.
// A new request is taken while an earlier response still waits to be taken.
module sorted_priority_queue #(
	parameter int DEPTH    = 16,
	parameter int KEY_BITS = 16,
	parameter int TAG_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam int CMP_W    = (CNT_BITS > spq_pkg::POS_W) ? CNT_BITS : spq_pkg::POS_W;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	logic [1:0]                  state_q;
	logic [2:0]                  type_q;
	logic [KEY_BITS-1:0]         key_q;
	logic [TAG_BITS-1:0]         tag_q;
	logic [spq_pkg::POS_W-1:0]   pos_q;
	logic [CNT_BITS-1:0]         count_q;
	logic [CNT_BITS-1:0]         scan_q;
	logic [CNT_BITS-1:0]         removed_q;
	logic                        rsp_valid_q;
	logic                        ok_q;
	logic [TAG_BITS-1:0]         otag_q;
	logic [KEY_BITS-1:0]         okey_q;
	logic [spq_pkg::CNT_W-1:0]   opos_q;
	logic [spq_pkg::CNT_W-1:0]   occ_q;

	spq_pkg::cell_ctrl_t         ctrl;
	logic [CNT_BITS-1:0]         rem_pos;
	logic [KEY_BITS-1:0]         cell_key [DEPTH];
	logic [TAG_BITS-1:0]         cell_tag [DEPTH];
	logic [DEPTH-1:0]            cell_le;

	logic                        out_free;
	logic [CNT_BITS-1:0]         target;
	logic [CNT_BITS-1:0]         sel;
	logic                        in_range;
	logic [KEY_BITS-1:0]         rd_key;
	logic [TAG_BITS-1:0]         rd_tag;
	logic [CNT_BITS-1:0]         ins_pos;
	logic                        done;
	logic                        res_ok;
	logic [TAG_BITS-1:0]         res_tag;
	logic [KEY_BITS-1:0]         res_key;
	logic [CNT_BITS-1:0]         res_pos;
	logic [CNT_BITS-1:0]         count_d;
	logic [1:0]                  state_d;
	logic [CNT_BITS-1:0]         scan_d;
	logic [CNT_BITS-1:0]         removed_d;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			spq_cell #(
				.KEY_BITS(KEY_BITS),
				.TAG_BITS(TAG_BITS),
				.CNT_BITS(CNT_BITS),
				.IDX(g)
			) u_cell (
				.clk(clk),
				.ctrl(ctrl),
				.count(count_q),
				.rem_pos(rem_pos),
				.new_key(key_q),
				.new_tag(tag_q),
				.prev_le((g == 0) ? 1'b1 : cell_le[(g == 0) ? 0 : g-1]),
				.prev_key((g == 0) ? '0 : cell_key[(g == 0) ? 0 : g-1]),
				.prev_tag((g == 0) ? '0 : cell_tag[(g == 0) ? 0 : g-1]),
				.next_key((g == DEPTH-1) ? '0 : cell_key[(g == DEPTH-1) ? g : g+1]),
				.next_tag((g == DEPTH-1) ? '0 : cell_tag[(g == DEPTH-1) ? g : g+1]),
				.le(cell_le[g]),
				.key_q(cell_key[g]),
				.tag_q(cell_tag[g])
			);
		end
	endgenerate

	assign out_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);

	always_comb begin
		target = '0;
		if (type_q == spq_pkg::REQ_READ_AT || type_q == spq_pkg::REQ_REM_AT) begin
			target = CNT_BITS'(pos_q);
		end
		in_range = (CMP_W'(type_q == spq_pkg::REQ_READ_AT || type_q == spq_pkg::REQ_REM_AT
			? pos_q : '0)) < CMP_W'(count_q);
		sel = (state_q == ST_SCAN) ? scan_q : target;
	end

	always_comb begin
		rd_key  = '0;
		rd_tag  = '0;
		ins_pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (sel == CNT_BITS'(i)) begin
				rd_key = rd_key | cell_key[i];
				rd_tag = rd_tag | cell_tag[i];
			end
			if (cell_le[i]) begin
				ins_pos = CNT_BITS'(i + 1);
			end
		end
	end

	always_comb begin
		ctrl      = '0;
		rem_pos   = sel;
		done      = 1'b0;
		res_ok    = 1'b0;
		res_tag   = '0;
		res_key   = '0;
		res_pos   = '0;
		count_d   = count_q;
		state_d   = state_q;
		scan_d    = scan_q;
		removed_d = removed_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (type_q == spq_pkg::REQ_REM_TAG) begin
					state_d   = ST_SCAN;
					scan_d    = '0;
					removed_d = '0;
				end else if (out_free) begin
					done    = 1'b1;
					state_d = ST_IDLE;
					case (type_q)
						spq_pkg::REQ_INSERT: begin
							if (count_q < CNT_BITS'(DEPTH)) begin
								ctrl.ins = 1'b1;
								count_d  = count_q + 1'b1;
								res_ok   = 1'b1;
								res_pos  = ins_pos;
							end
						end
						spq_pkg::REQ_POLL, spq_pkg::REQ_PEEK,
						spq_pkg::REQ_READ_AT, spq_pkg::REQ_REM_AT: begin
							if (in_range) begin
								res_ok  = 1'b1;
								res_tag = rd_tag;
								res_key = rd_key;
								if (type_q == spq_pkg::REQ_POLL || type_q == spq_pkg::REQ_REM_AT) begin
									ctrl.rem = 1'b1;
									count_d  = count_q - 1'b1;
								end
							end
						end
						spq_pkg::REQ_COUNT: begin
							res_ok  = 1'b1;
							res_pos = count_q;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_q >= count_q) begin
					if (out_free) begin
						done    = 1'b1;
						state_d = ST_IDLE;
						res_ok  = (removed_q != '0);
						res_pos = removed_q;
					end
				end else if (rd_tag == tag_q) begin
					ctrl.rem  = 1'b1;
					count_d   = count_q - 1'b1;
					removed_d = removed_q + 1'b1;
				end else begin
					scan_d = scan_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_q    <= scan_d;
		removed_q <= removed_d;
		if (req.valid && req.ready) begin
			type_q <= req.req_type;
			key_q  <= req.prio_key;
			tag_q  <= req.entry_tag;
			pos_q  <= req.position;
		end
		if (done) begin
			ok_q   <= res_ok;
			otag_q <= res_tag;
			okey_q <= res_key;
			opos_q <= spq_pkg::CNT_W'(res_pos);
			occ_q  <= spq_pkg::CNT_W'(count_d);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.ok           = ok_q;
	assign rsp.out_tag      = otag_q;
	assign rsp.out_key      = okey_q;
	assign rsp.out_position = opos_q;
	assign rsp.occupancy    = occ_q;

endmodule

// ===== src/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
module spq_checker #(
	parameter int DEPTH    = 16,
	parameter int KEY_BITS = 16,
	parameter int TAG_BITS = 8
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic                       ok,
	input logic [KEY_BITS-1:0]        out_key,
	input logic [spq_pkg::CNT_W-1:0]  occupancy
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_key) && $stable(occupancy))
		else $error("Response changed while stalled.");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (DEPTH >= 32) || (occupancy <= spq_pkg::CNT_W'(DEPTH)))
		else $error("Occupancy exceeds the queue depth.");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("Request taken while the previous one is in progress.");

	a_fail_zero_key: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !ok |-> out_key == '0)
		else $error("Failed request returned a key.");

endmodule

bind sorted_priority_queue spq_checker #(
	.DEPTH(DEPTH),
	.KEY_BITS(KEY_BITS),
	.TAG_BITS(TAG_BITS)
) u_spq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.ok(rsp.ok),
	.out_key(rsp.out_key),
	.occupancy(rsp.occupancy)
);
